FILE: sv/prdu_pkg.sv
// Shared types and constants for the pad report port decode unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package prdu_pkg;

  localparam int PORT_COUNT    = 4;
  localparam int PORT_W        = 2;
  localparam int BLOCK_ANALOGS = 6;

  localparam logic [7:0] LINK_BITS   = 8'h30;
  localparam logic [7:0] ANALOG_HELD = 8'd200;
  localparam logic signed [8:0] AXIS_HI = 9'sd127;
  localparam logic signed [8:0] AXIS_LO = -9'sd128;

  // register indexes on the configuration port
  localparam logic REG_ADAPTER_ONLINE = 1'b0;

  // analog byte slots within a port block
  localparam int AN_MAIN_X = 0;
  localparam int AN_MAIN_Y = 1;
  localparam int AN_SUB_X  = 2;
  localparam int AN_SUB_Y  = 3;
  localparam int AN_LEFT   = 4;
  localparam int AN_RIGHT  = 5;

  typedef logic [PORT_W-1:0] port_t;
  typedef logic [BLOCK_ANALOGS-1:0][7:0] analogs_t;

  typedef struct packed {
    port_t      port_index;
    logic [7:0] status_byte;
    logic [7:0] buttons_first;
    logic [7:0] buttons_second;
    analogs_t   raw;
  } block_t;

  typedef struct packed {
    logic        present;
    logic [15:0] button_word;
    logic [7:0]  main_x;
    logic [7:0]  main_y;
    logic [7:0]  sub_x;
    logic [7:0]  sub_y;
    logic [7:0]  left_trigger;
    logic [7:0]  right_trigger;
    logic [7:0]  analog_a;
    logic [7:0]  analog_b;
  } result_t;

  // rest position update, applied when a word leaves the decode stage
  typedef struct packed {
    logic     load;
    logic     drop;
    port_t    port;
    analogs_t raw;
  } rest_upd_t;

endpackage

`default_nettype wire

FILE: sv/pad_report_port_decode_unit.sv
// Top level of the pad report port decode unit: input register, decode,
// rest store, result register and the configuration port.
// Depends on prdu_pkg, prdu_rest_store and prdu_decode.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one nine-byte port block per
//   word, tagged with port_index. Output channel (out_valid/out_ready)
//   returns one decoded pad record per input word, in order.
//   The APB port holds adapter_online at address 0; writing it from 0 to 1
//   drops every stored rest position so they are captured again.
//   An accepted word lands in the input register, then moves to the result
//   register (raising out_valid) when that register frees. Throughput: one
//   word per cycle while out_ready is high, set by the single decode stage.
//   Stall: when out_ready is low the result holds, the input register
//   holds its word, and in_ready falls once both are full; no word is
//   lost. Rest positions update only when a word moves to the result
//   register, so back-to-back words on one port see each other's update.
//   Reset (rst, synchronous): both registers empty, adapter offline,
//   every rest position invalid.
`timescale 1ns / 1ps
`default_nettype none

module pad_report_port_decode_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input words
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  port_index,
  input  wire logic [7:0]  status_byte,
  input  wire logic [7:0]  buttons_first,
  input  wire logic [7:0]  buttons_second,
  input  wire logic [7:0]  main_x_raw,
  input  wire logic [7:0]  main_y_raw,
  input  wire logic [7:0]  sub_x_raw,
  input  wire logic [7:0]  sub_y_raw,
  input  wire logic [7:0]  left_analog_raw,
  input  wire logic [7:0]  right_analog_raw,
  // result words
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             present,
  output logic [15:0]      button_word,
  output logic signed [7:0] main_x,
  output logic signed [7:0] main_y,
  output logic signed [7:0] sub_x,
  output logic signed [7:0] sub_y,
  output logic [7:0]       left_trigger,
  output logic [7:0]       right_trigger,
  output logic [7:0]       analog_a,
  output logic [7:0]       analog_b
);
  import prdu_pkg::*;

  logic      online;
  logic      cfg_wr;
  logic      link_clear;
  logic      s1_valid;
  block_t    s1_blk;
  logic      s1_adv;
  logic      rd_valid;
  analogs_t  rd_rest;
  result_t   res;
  result_t   res_q;
  rest_upd_t upd;
  rest_upd_t upd_gated;

  // configuration port
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_ADAPTER_ONLINE);
  assign link_clear = cfg_wr && pwdata[0] && !online;
  assign prdata     = (paddr[2] == REG_ADAPTER_ONLINE) ? {31'd0, online} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      online <= 1'b0;
    end else if (cfg_wr) begin
      online <= pwdata[0];
    end
  end

  // handshake: advance the decode stage whenever the result register frees
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_blk.port_index     <= port_index;
      s1_blk.status_byte    <= status_byte;
      s1_blk.buttons_first  <= buttons_first;
      s1_blk.buttons_second <= buttons_second;
      s1_blk.raw[AN_MAIN_X] <= main_x_raw;
      s1_blk.raw[AN_MAIN_Y] <= main_y_raw;
      s1_blk.raw[AN_SUB_X]  <= sub_x_raw;
      s1_blk.raw[AN_SUB_Y]  <= sub_y_raw;
      s1_blk.raw[AN_LEFT]   <= left_analog_raw;
      s1_blk.raw[AN_RIGHT]  <= right_analog_raw;
    end
    if (s1_adv) begin
      res_q <= res;
    end
  end

  prdu_decode u_decode (
    .online     (online),
    .blk        (s1_blk),
    .rest_valid (rd_valid),
    .rest_in    (rd_rest),
    .res        (res),
    .upd        (upd)
  );

  // commit the rest update only with the word that caused it
  always_comb begin
    upd_gated      = upd;
    upd_gated.load = upd.load && s1_adv;
    upd_gated.drop = upd.drop && s1_adv;
  end

  prdu_rest_store u_rest (
    .clk        (clk),
    .rst        (rst),
    .link_clear (link_clear),
    .upd        (upd_gated),
    .rd_port    (s1_blk.port_index),
    .rd_valid   (rd_valid),
    .rd_rest    (rd_rest)
  );

  assign present       = res_q.present;
  assign button_word   = res_q.button_word;
  assign main_x        = $signed(res_q.main_x);
  assign main_y        = $signed(res_q.main_y);
  assign sub_x         = $signed(res_q.sub_x);
  assign sub_y         = $signed(res_q.sub_y);
  assign left_trigger  = res_q.left_trigger;
  assign right_trigger = res_q.right_trigger;
  assign analog_a      = res_q.analog_a;
  assign analog_b      = res_q.analog_b;

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !present |-> button_word == 16'd0 && main_x == 8'sd0 && main_y == 8'sd0
      && sub_x == 8'sd0 && sub_y == 8'sd0 && left_trigger == 8'd0
      && right_trigger == 8'd0 && analog_a == 8'd0 && analog_b == 8'd0)
    else $error("absent result carries nonzero fields");

  a_analog_a: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> analog_a == (button_word[8] ? ANALOG_HELD : 8'd0))
    else $error("analog A does not follow button A");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while decode stage is stalled");

  a_first_capture_zero: assert property (@(posedge clk) disable iff (rst)
    s1_adv && upd.load |=> main_x == 8'sd0 && left_trigger == 8'd0 && present)
    else $error("first present word not zero offset");

endmodule

`default_nettype wire

FILE: sv/prdu_rest_store.sv
// Per-port rest positions and their valid bits.
// Depends on prdu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prdu_rest_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                link_clear,
  input  wire prdu_pkg::rest_upd_t upd,
  input  wire prdu_pkg::port_t     rd_port,
  output logic                     rd_valid,
  output prdu_pkg::analogs_t       rd_rest
);
  import prdu_pkg::*;

  analogs_t                rest [PORT_COUNT];
  logic [PORT_COUNT-1:0]   valid;

  assign rd_valid = valid[rd_port];
  assign rd_rest  = rest[rd_port];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (link_clear) begin
      valid <= '0;
    end else if (upd.load) begin
      valid[upd.port] <= 1'b1;
    end else if (upd.drop) begin
      valid[upd.port] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.load) begin
      rest[upd.port] <= upd.raw;
    end
  end

endmodule

`default_nettype wire

FILE: sv/prdu_decode.sv
// Decode of one port block: presence, button remap, rest offsets.
// Depends on prdu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prdu_decode (
  input  wire logic                online,
  input  wire prdu_pkg::block_t    blk,
  input  wire logic                rest_valid,
  input  wire prdu_pkg::analogs_t  rest_in,
  output prdu_pkg::result_t        res,
  output prdu_pkg::rest_upd_t      upd
);
  import prdu_pkg::*;

  function automatic logic [7:0] axis_offset(input logic [7:0] raw, input logic [7:0] rst_pos);
    logic signed [8:0] d;
    d = $signed({1'b0, raw}) - $signed({1'b0, rst_pos});
    if (d > AXIS_HI)      return AXIS_HI[7:0];
    else if (d < AXIS_LO) return AXIS_LO[7:0];
    else                  return d[7:0];
  endfunction

  function automatic logic [7:0] trigger_offset(input logic [7:0] raw, input logic [7:0] rst_pos);
    return (raw > rst_pos) ? 8'(raw - rst_pos) : 8'd0;
  endfunction

  logic     in_range;
  logic     linked;
  logic     present;
  analogs_t rest_use;
  logic [15:0] buttons;

  assign in_range = (32'(blk.port_index) < PORT_COUNT);
  assign linked   = (blk.status_byte & LINK_BITS) != 8'h00;
  assign present  = online && in_range && linked;

  // first present word: its own bytes become the rest position
  assign rest_use = rest_valid ? rest_in : blk.raw;

  assign buttons = {3'b000,
                    blk.buttons_second[0],     // start
                    blk.buttons_first[3:0],    // Y X B A
                    1'b0,
                    blk.buttons_second[3:1],   // L R Z
                    blk.buttons_first[7:4]};   // up down right left

  assign upd.load = present && !rest_valid;
  assign upd.drop = online && in_range && !linked;
  assign upd.port = blk.port_index;
  assign upd.raw  = blk.raw;

  always_comb begin
    res = '0;
    if (present) begin
      res.present       = 1'b1;
      res.button_word   = buttons;
      res.main_x        = axis_offset(blk.raw[AN_MAIN_X], rest_use[AN_MAIN_X]);
      res.main_y        = axis_offset(blk.raw[AN_MAIN_Y], rest_use[AN_MAIN_Y]);
      res.sub_x         = axis_offset(blk.raw[AN_SUB_X], rest_use[AN_SUB_X]);
      res.sub_y         = axis_offset(blk.raw[AN_SUB_Y], rest_use[AN_SUB_Y]);
      res.left_trigger  = trigger_offset(blk.raw[AN_LEFT], rest_use[AN_LEFT]);
      res.right_trigger = trigger_offset(blk.raw[AN_RIGHT], rest_use[AN_RIGHT]);
      res.analog_a      = buttons[8] ? ANALOG_HELD : 8'd0;
      res.analog_b      = buttons[9] ? ANALOG_HELD : 8'd0;
    end
  end

endmodule

`default_nettype wire
